### rtl/core/iehb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and one's-complement helpers for the ICMP echo header builder.
// No dependencies.
package iehb_pkg;

    localparam int BYTE_CNT_W  = 11;
    localparam int SUM_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int HDR_BYTES   = 28;

    // configuration register indexes
    localparam logic [1:0] CFG_DEST_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_ECHO_IDENTIFIER = 2'd1;
    localparam logic [1:0] CFG_PKT_LIMIT       = 2'd2;

    localparam logic [31:0]          RST_DEST_ADDRESS    = 32'd0;
    localparam logic [15:0]          RST_ECHO_IDENTIFIER = 16'd12345;
    localparam logic [BYTE_CNT_W-1:0] RST_PKT_LIMIT      = 11'd1472;

    // header word positions
    localparam logic [2:0] WORD_VER_LEN   = 3'd0;
    localparam logic [2:0] WORD_IDENT     = 3'd1;
    localparam logic [2:0] WORD_TTL_CKSUM = 3'd2;
    localparam logic [2:0] WORD_SRC_ADDR  = 3'd3;
    localparam logic [2:0] WORD_DST_ADDR  = 3'd4;
    localparam logic [2:0] WORD_ICMP_TYPE = 3'd5;
    localparam logic [2:0] WORD_ICMP_ID   = 3'd6;

    localparam logic [15:0] IP_VER_IHL    = 16'h4500;
    localparam logic [31:0] IP_ID_FRAG    = 32'h0009_0000;
    localparam logic [15:0] IP_TTL_PROTO  = 16'h7f01;
    localparam logic [31:0] IP_SRC        = 32'h0000_0000;
    localparam logic [15:0] ICMP_TYPE_CODE = 16'h0800;
    // 0x4500 + 0x0009 + 0x7f01, the fixed part of the IPv4 header sum
    localparam logic [15:0] IP_FIXED_SUM  = 16'hc40a;

    typedef struct packed {
        logic [BYTE_CNT_W-1:0] byte_count;
        logic [SUM_W-1:0]      payload_sum;
        logic [15:0]           sequence_number;
    } desc_t;

    typedef struct packed {
        logic  push;
        desc_t desc;
    } desc_push_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // sum of four 16-bit words folded back to 16 bits with end-around carry
    function automatic logic [15:0] oc_sum4(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c, input logic [15:0] d);
        logic [17:0] s;
        logic [16:0] f;
        s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
        f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

endpackage

### rtl/core/icmp_echo_header_builder.sv
`timescale 1ns / 1ps
// Top level of the ICMP echo header builder: configuration registers and block wiring.
// Depends on iehb_pkg, iehb_front, iehb_queue, iehb_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  cfg     | in        | cfg_wr_en          | cfg_index, cfg_wdata
//  s_      | in        | s_valid / s_ready  | s_payload_byte, s_last_byte
//  m_      | out       | m_valid / m_ready  | m_header_word, m_word_index, m_last_word
//
// One payload byte is taken per cycle; its add into the running sum is the front-end limit.
// A closing byte yields seven header words, one per cycle from the back end's output register while m_ready is high.
// A queue of four closed packets sits between the two, so bytes keep flowing while words drain.
// The front stalls only on a closing byte with the queue full. Synchronous active-low reset.
module icmp_echo_header_builder import iehb_pkg::*; #(
    parameter int MTU_BYTES = 1500
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_header_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    logic [31:0]           dest_reg;
    logic [15:0]           ident_reg;
    logic [BYTE_CNT_W-1:0] maxp_reg;

    desc_push_t q_push;
    desc_t      q_head;
    logic       q_full, q_empty, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_reg  <= RST_DEST_ADDRESS;
            ident_reg <= RST_ECHO_IDENTIFIER;
            maxp_reg  <= RST_PKT_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEST_ADDRESS:    dest_reg  <= cfg_wdata;
                CFG_ECHO_IDENTIFIER: ident_reg <= cfg_wdata[15:0];
                CFG_PKT_LIMIT:       maxp_reg  <= cfg_wdata[BYTE_CNT_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    iehb_front #(
        .MTU_BYTES (MTU_BYTES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pkt_limit      (maxp_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .q_full         (q_full),
        .q_push         (q_push)
    );

    iehb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    iehb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .dest_address    (dest_reg),
        .echo_identifier (ident_reg),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_header_word   (m_header_word),
        .m_word_index    (m_word_index),
        .m_last_word     (m_last_word)
    );

endmodule

### rtl/core/iehb_front.sv
`timescale 1ns / 1ps
// Front end: accepts payload bytes, keeps count and running sum, closes packets.
// Depends on iehb_pkg.
module iehb_front import iehb_pkg::*; #(
    parameter int MTU_BYTES = 1500
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [BYTE_CNT_W-1:0] pkt_limit,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_payload_byte,
    input  logic                  s_last_byte,
    input  logic                  q_full,
    output desc_push_t            q_push
);

    localparam int CAP = MTU_BYTES - HDR_BYTES;
    localparam logic [BYTE_CNT_W-1:0] CAP_LIM =
        (CAP > (2 ** BYTE_CNT_W) - 1) ? {BYTE_CNT_W{1'b1}} : BYTE_CNT_W'(CAP);

    logic [BYTE_CNT_W-1:0] bc_reg, bc_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [7:0]            hold_reg, hold_next;
    logic [15:0]           seq_reg, seq_next;

    logic [BYTE_CNT_W-1:0] limit, bc_inc;
    logic [15:0]           operand, add_res;
    logic                  close, accept;

    always_comb begin
        limit = (pkt_limit == '0) ? BYTE_CNT_W'(1) : pkt_limit;
        if (limit > CAP_LIM) begin
            limit = CAP_LIM;
        end
    end

    assign bc_inc  = bc_reg + BYTE_CNT_W'(1);
    assign close   = s_last_byte || !(bc_inc < limit);
    assign s_ready = !close || !q_full;
    assign accept  = s_valid && s_ready;

    // odd count pairs with the held high byte, otherwise pad the low byte with zero
    assign operand = bc_reg[0] ? {hold_reg, s_payload_byte} : {s_payload_byte, 8'h00};
    assign add_res = oc_add(sum_reg, operand);

    always_comb begin
        bc_next   = bc_reg;
        sum_next  = sum_reg;
        hold_next = hold_reg;
        seq_next  = seq_reg;
        q_push.push                 = 1'b0;
        q_push.desc.byte_count      = bc_inc;
        q_push.desc.payload_sum     = add_res;
        q_push.desc.sequence_number = seq_reg;
        if (accept) begin
            if (close) begin
                q_push.push = 1'b1;
                bc_next     = '0;
                sum_next    = '0;
                hold_next   = '0;
                seq_next    = seq_reg + 16'd1;
            end else begin
                bc_next = bc_inc;
                if (bc_reg[0]) begin
                    sum_next = add_res;
                end else begin
                    hold_next = s_payload_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg   <= '0;
            sum_reg  <= '0;
            hold_reg <= '0;
            seq_reg  <= '0;
        end else begin
            bc_reg   <= bc_next;
            sum_reg  <= sum_next;
            hold_reg <= hold_next;
            seq_reg  <= seq_next;
        end
    end

endmodule

### rtl/core/iehb_queue.sv
`timescale 1ns / 1ps
// Small register FIFO of closed-packet descriptors between front and back end.
// Depends on iehb_pkg.
module iehb_queue import iehb_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  desc_push_t q_push,
    output logic       q_full,
    input  logic       q_pop,
    output logic       q_empty,
    output desc_t      q_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    desc_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_empty = (cnt_reg == '0);
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_push.desc;
        end
    end

endmodule

### rtl/core/iehb_back.sv
`timescale 1ns / 1ps
// Back end: pops a descriptor, forms both checksums, streams seven header words.
// Depends on iehb_pkg.
module iehb_back import iehb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] dest_address,
    input  logic [15:0] echo_identifier,
    input  logic        q_empty,
    input  desc_t       q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_header_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    logic        cur_valid_reg, cur_valid_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] total_reg, ip_ck_reg, icmp_ck_reg, seq_reg;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] word_reg;
    logic [2:0]  widx_reg;
    logic        wlast_reg;

    logic [15:0] head_total, head_ip_ck, head_icmp_ck;
    logic [31:0] word;
    logic        load, load_cur;

    assign head_total   = 16'(HDR_BYTES) + {5'd0, q_head.byte_count};
    assign head_ip_ck   = ~oc_sum4(IP_FIXED_SUM, head_total,
                                   dest_address[31:16], dest_address[15:0]);
    assign head_icmp_ck = ~oc_sum4(ICMP_TYPE_CODE, echo_identifier,
                                   q_head.sequence_number, q_head.payload_sum);

    always_comb begin
        unique case (idx_reg)
            WORD_VER_LEN:   word = {IP_VER_IHL, total_reg};
            WORD_IDENT:     word = IP_ID_FRAG;
            WORD_TTL_CKSUM: word = {IP_TTL_PROTO, ip_ck_reg};
            WORD_SRC_ADDR:  word = IP_SRC;
            WORD_DST_ADDR:  word = dest_address;
            WORD_ICMP_TYPE: word = {ICMP_TYPE_CODE, icmp_ck_reg};
            WORD_ICMP_ID:   word = {echo_identifier, seq_reg};
            default:        word = '0;
        endcase
    end

    // advance when the output register is free or being drained
    assign load = cur_valid_reg && (!m_valid_reg || m_ready);

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        load_cur       = 1'b0;
        if (load) begin
            m_valid_next = 1'b1;
            if (idx_reg == WORD_ICMP_ID) begin
                load_cur       = !q_empty;
                cur_valid_next = !q_empty;
                idx_next       = WORD_VER_LEN;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end else if (!cur_valid_reg && !q_empty) begin
            load_cur       = 1'b1;
            cur_valid_next = 1'b1;
            idx_next       = WORD_VER_LEN;
        end
    end

    assign q_pop = load_cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= WORD_VER_LEN;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_cur) begin
            total_reg   <= head_total;
            ip_ck_reg   <= head_ip_ck;
            icmp_ck_reg <= head_icmp_ck;
            seq_reg     <= q_head.sequence_number;
        end
        if (load) begin
            word_reg  <= word;
            widx_reg  <= idx_reg;
            wlast_reg <= (idx_reg == WORD_ICMP_ID);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_header_word = word_reg;
    assign m_word_index  = widx_reg;
    assign m_last_word   = wlast_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for icmp_echo_header_builder: a directed byte table, then random
// phases under changing backpressure, each header word checked against an in-bench predictor or a typed header.
// Depends on iehb_pkg and the block's RTL.
module tb import iehb_pkg::*; ();

    localparam int MTU           = 1500;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_PRINTED   = 30;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } hdr_word_t;

    // known selects a typed header (1..3) for the packet closed by this byte, 0 = predicted
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] known;
    } byte_row_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [1:0]  cfg_index      = '0;
    logic [31:0] cfg_wdata      = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_payload_byte = '0;
    logic        s_last_byte    = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_header_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    // travels with the byte in flight so the scoreboard sees it at acceptance
    logic [1:0]  row_known = '0;

    logic [31:0] dest_addr_q   = RST_DEST_ADDRESS;
    logic [15:0] echo_id_q     = RST_ECHO_IDENTIFIER;
    logic [10:0] pkt_limit_q   = RST_PKT_LIMIT;

    logic [10:0] bytes_seen   = '0;
    logic [15:0] payload_csum = '0;
    logic [7:0]  pending_high = '0;
    logic [15:0] echo_seq     = '0;

    hdr_word_t   hdr_words_due[$];
    logic [31:0] known_hdr [1:3][0:6];

    int snd_idle_pct  = 10;
    int rcv_idle_pct  = 76;
    int cycles        = 0;
    int mismatches    = 0;
    int bytes_taken   = 0;
    int packets_built = 0;
    int words_checked = 0;
    int configs_run   = 0;

    byte_row_t dir_rows [0:15] = '{
        '{8'h00, 1'b1, 2'd1},
        '{8'hFF, 1'b1, 2'd2},
        '{8'h12, 1'b0, 2'd0}, '{8'h34, 1'b0, 2'd0}, '{8'h56, 1'b1, 2'd0},
        // payload chosen so the ICMP checksum comes out as zero
        '{8'hC7, 1'b0, 2'd0}, '{8'hC3, 1'b1, 2'd3},
        '{8'hFF, 1'b0, 2'd0}, '{8'hFF, 1'b1, 2'd0},
        '{8'h00, 1'b0, 2'd0}, '{8'h80, 1'b0, 2'd0}, '{8'h01, 1'b0, 2'd0}, '{8'h7F, 1'b1, 2'd0},
        '{8'hAA, 1'b0, 2'd0}, '{8'h55, 1'b0, 2'd0}, '{8'hFF, 1'b1, 2'd0}
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    icmp_echo_header_builder #(
        .MTU_BYTES(MTU)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload_byte(s_payload_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_header_word (m_header_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] t;
        t = {16'd0, a} + {16'd0, b};
        t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
        return t[15:0];
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        end
    endtask

    // Fold one payload byte into the running sum; on close, queue the seven header words.
    task automatic take_payload_byte(input logic [7:0] data, input logic last,
                                     input logic [1:0] known);
        logic [15:0] csum;
        logic [15:0] total;
        logic [15:0] ip_sum;
        logic [15:0] icmp_sum;
        logic [31:0] w [0:6];
        hdr_word_t   nw;
        int          lim;
        csum = payload_csum;
        if (bytes_seen[0]) begin
            csum = ones_add(csum, {pending_high, data});
        end else begin
            pending_high = data;
        end
        bytes_seen   = bytes_seen + 11'd1;
        payload_csum = csum;
        lim = int'(pkt_limit_q);
        if (lim == 0) lim = 1;
        if (lim > MTU - HDR_BYTES) lim = MTU - HDR_BYTES;
        if (!last && int'(bytes_seen) < lim) return;

        // pad an odd trailing byte with a zero low byte
        if (bytes_seen[0]) csum = ones_add(csum, {pending_high, 8'h00});
        total = 16'(HDR_BYTES) + {5'd0, bytes_seen};

        ip_sum = ones_add(IP_VER_IHL, total);
        ip_sum = ones_add(ip_sum, IP_ID_FRAG[31:16]);
        ip_sum = ones_add(ip_sum, IP_TTL_PROTO);
        ip_sum = ones_add(ip_sum, dest_addr_q[31:16]);
        ip_sum = ones_add(ip_sum, dest_addr_q[15:0]);

        icmp_sum = ones_add(ICMP_TYPE_CODE, echo_id_q);
        icmp_sum = ones_add(icmp_sum, echo_seq);
        icmp_sum = ones_add(icmp_sum, csum);

        w[WORD_VER_LEN]   = {IP_VER_IHL, total};
        w[WORD_IDENT]     = IP_ID_FRAG;
        w[WORD_TTL_CKSUM] = {IP_TTL_PROTO, ~ip_sum};
        w[WORD_SRC_ADDR]  = IP_SRC;
        w[WORD_DST_ADDR]  = dest_addr_q;
        w[WORD_ICMP_TYPE] = {ICMP_TYPE_CODE, ~icmp_sum};
        w[WORD_ICMP_ID]   = {echo_id_q, echo_seq};

        for (int k = 0; k < 7; k++) begin
            nw.word  = (known != 2'd0) ? known_hdr[known][k] : w[k];
            nw.index = 3'(k);
            nw.last  = (3'(k) == WORD_ICMP_ID);
            hdr_words_due = {hdr_words_due, nw};
        end

        bytes_seen   = '0;
        payload_csum = '0;
        pending_high = '0;
        echo_seq     = echo_seq + 16'd1;
        packets_built++;
    endtask

    // Scoreboard and receiver: inputs are predicted before outputs are compared.
    always @(posedge aclk) begin
        hdr_word_t due;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                take_payload_byte(s_payload_byte, s_last_byte, row_known);
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                if (hdr_words_due.size() == 0) begin
                    flag_mismatch("word with nothing due", m_header_word, 32'h0);
                end else begin
                    due = hdr_words_due.pop_front();
                    words_checked++;
                    if (m_header_word !== due.word)
                        flag_mismatch($sformatf("word %0d data", due.index),
                                      m_header_word, due.word);
                    if (m_word_index !== due.index)
                        flag_mismatch("word index", {29'd0, m_word_index}, {29'd0, due.index});
                    if (m_last_word !== due.last)
                        flag_mismatch($sformatf("word %0d last flag", due.index),
                                      {31'd0, m_last_word}, {31'd0, due.last});
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycles, hdr_words_due.size());
            $display("** icmp_echo_header_builder: FAILED **");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last,
                             input logic [1:0] known);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= data;
        s_last_byte    <= last;
        row_known      <= known;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off until every header word is in, then let the queue and back end settle.
    task automatic drain;
        s_valid <= 1'b0;
        // let the scoreboard take the final transaction first
        @(posedge aclk);
        while (hdr_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_DEST_ADDRESS:    dest_addr_q = data;
            CFG_ECHO_IDENTIFIER: echo_id_q   = data[15:0];
            CFG_PKT_LIMIT:       pkt_limit_q = data[10:0];
            default: ;
        endcase
    endtask

    // One idle-time configuration, a stream of random bytes, and a closing byte.
    task automatic run_phase(input logic [31:0] dest, input logic [15:0] ident,
                             input logic [10:0] maxp, input int nbytes, input int last_pct);
        write_reg(CFG_DEST_ADDRESS, dest);
        write_reg(CFG_ECHO_IDENTIFIER, {16'd0, ident});
        write_reg(CFG_PKT_LIMIT, {21'd0, maxp});
        cfg_wr_en <= 1'b0;
        configs_run++;
        for (int i = 0; i < nbytes; i++) begin
            send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 99) < last_pct), 2'd0);
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1, 2'd0);
        drain();
    endtask

    initial begin
        known_hdr[1] = '{32'h4500001D, 32'h00090000, 32'h7F013BD8, 32'h00000000,
                         32'h00000000, 32'h0800C7C6, 32'h30390000};
        known_hdr[2] = '{32'h4500001D, 32'h00090000, 32'h7F013BD8, 32'h00000000,
                         32'h00000000, 32'h0800C8C4, 32'h30390001};
        known_hdr[3] = '{32'h4500001E, 32'h00090000, 32'h7F013BD7, 32'h00000000,
                         32'h00000000, 32'h08000000, 32'h30390003};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table under the reset configuration
        configs_run++;
        foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].known);
        drain();

        // sender idles lightly, receiver heavily
        snd_idle_pct = 10;
        rcv_idle_pct = 76;
        run_phase($urandom, 16'($urandom_range(0, 65535)), 11'd0, 30, 0);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 11'd1, 30, 0);
        run_phase($urandom, 16'h0000, 11'd2, 40, 0);

        // the other way round
        snd_idle_pct = 76;
        rcv_idle_pct = 10;
        run_phase($urandom, 16'($urandom_range(0, 65535)), 11'($urandom_range(3, 40)), 100, 5);
        // one-byte packets with this address give an IPv4 checksum of zero
        run_phase(32'h0000_3BD8, 16'($urandom_range(0, 65535)), 11'd1, 20, 0);
        // limit above the MTU clamp: packets close on the last flag only
        run_phase($urandom, 16'($urandom_range(0, 65535)), 11'h7FF, 80, 5);

        // no idling on either side
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase($urandom, 16'($urandom_range(0, 65535)), RST_PKT_LIMIT, 60, 10);
        run_phase($urandom, 16'($urandom_range(0, 65535)), 11'($urandom_range(1, 64)), 86, 8);

        $display("Covered %0d payload bytes in %0d packets across %0d register settings,",
                 bytes_taken, packets_built, configs_run);
        $display("with %0d header words compared and %0d mismatches.",
                 words_checked, mismatches);
        if (mismatches == 0 && hdr_words_due.size() == 0) begin
            $display("** icmp_echo_header_builder: PASSED **");
        end else begin
            $display("** icmp_echo_header_builder: FAILED **");
        end
        $finish;
    end

endmodule
